>>> rtl/tia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tia_pkg: shared codes for the tagged integer ALU
// Opcodes as they arrive, internal operation classes and result kinds.
// ----------------------------------------------------------------------------
package tia_pkg;

    localparam int CMD_BITS   = 5;
    localparam int VALUE_BITS = 16;

    typedef logic [CMD_BITS-1:0] cmd_t;
    typedef logic [3:0]          op_t;
    typedef logic [1:0]          kind_t;

    // Incoming opcodes.
    localparam cmd_t CMD_ADD   = 5'd0;
    localparam cmd_t CMD_SUB   = 5'd1;
    localparam cmd_t CMD_LT    = 5'd2;
    localparam cmd_t CMD_GT    = 5'd3;
    localparam cmd_t CMD_LE    = 5'd4;
    localparam cmd_t CMD_GE    = 5'd5;
    localparam cmd_t CMD_EQ    = 5'd6;
    localparam cmd_t CMD_NE    = 5'd7;
    localparam cmd_t CMD_MUL   = 5'd8;
    localparam cmd_t CMD_QUO   = 5'd9;
    localparam cmd_t CMD_REM   = 5'd10;
    localparam cmd_t CMD_AND   = 5'd11;
    localparam cmd_t CMD_XOR   = 5'd12;
    localparam cmd_t CMD_EQ2   = 5'd13;
    localparam cmd_t CMD_SHIFT = 5'd19;

    // Internal operation classes produced by the front end.
    localparam op_t OP_ADD   = 4'd0;
    localparam op_t OP_SUB   = 4'd1;
    localparam op_t OP_LT    = 4'd2;
    localparam op_t OP_GT    = 4'd3;
    localparam op_t OP_LE    = 4'd4;
    localparam op_t OP_GE    = 4'd5;
    localparam op_t OP_EQ    = 4'd6;
    localparam op_t OP_NE    = 4'd7;
    localparam op_t OP_MUL   = 4'd8;
    localparam op_t OP_QUO   = 4'd9;
    localparam op_t OP_REM   = 4'd10;
    localparam op_t OP_AND   = 4'd11;
    localparam op_t OP_XOR   = 4'd12;
    localparam op_t OP_SHIFT = 4'd13;
    localparam op_t OP_PASS  = 4'd14;

    // Result kinds.
    localparam kind_t KIND_INT   = 2'd0;
    localparam kind_t KIND_TRUE  = 2'd1;
    localparam kind_t KIND_FALSE = 2'd2;
    localparam kind_t KIND_NIL   = 2'd3;

endpackage
`default_nettype wire

>>> rtl/tia_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tia_front: item intake and classification
// Decodes the opcode, narrows the operands and holds items in a two-entry queue.
// ----------------------------------------------------------------------------
module tia_front #(
    parameter int W = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire tia_pkg::cmd_t                cmd,
    input  wire logic signed [tia_pkg::VALUE_BITS-1:0] first_value,
    input  wire logic signed [tia_pkg::VALUE_BITS-1:0] second_value,
    output logic                              q_valid,
    input  wire                               q_pop,
    output tia_pkg::op_t                      q_op,
    output logic [W-1:0]                      q_a,
    output logic [W-1:0]                      q_b
);
    localparam int IW = (W > tia_pkg::VALUE_BITS) ? W : tia_pkg::VALUE_BITS;

    tia_pkg::op_t   op_mem [2];
    logic [W-1:0]   a_mem  [2];
    logic [W-1:0]   b_mem  [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    tia_pkg::op_t   op_dec;
    logic [IW-1:0]  a_wide, b_wide;
    logic           push;

    // Operands are taken as two's complement in their low W bits.
    assign a_wide = IW'($unsigned(first_value));
    assign b_wide = IW'($unsigned(second_value));

    always_comb
    begin
        case (cmd)
            tia_pkg::CMD_ADD:   op_dec = tia_pkg::OP_ADD;
            tia_pkg::CMD_SUB:   op_dec = tia_pkg::OP_SUB;
            tia_pkg::CMD_LT:    op_dec = tia_pkg::OP_LT;
            tia_pkg::CMD_GT:    op_dec = tia_pkg::OP_GT;
            tia_pkg::CMD_LE:    op_dec = tia_pkg::OP_LE;
            tia_pkg::CMD_GE:    op_dec = tia_pkg::OP_GE;
            tia_pkg::CMD_EQ,
            tia_pkg::CMD_EQ2:   op_dec = tia_pkg::OP_EQ;
            tia_pkg::CMD_NE:    op_dec = tia_pkg::OP_NE;
            tia_pkg::CMD_MUL:   op_dec = tia_pkg::OP_MUL;
            tia_pkg::CMD_QUO:   op_dec = tia_pkg::OP_QUO;
            tia_pkg::CMD_REM:   op_dec = tia_pkg::OP_REM;
            tia_pkg::CMD_AND:   op_dec = tia_pkg::OP_AND;
            tia_pkg::CMD_XOR:   op_dec = tia_pkg::OP_XOR;
            tia_pkg::CMD_SHIFT: op_dec = tia_pkg::OP_SHIFT;
            default:            op_dec = tia_pkg::OP_PASS;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = op_mem[rd_ptr_reg];
    assign q_a     = a_mem[rd_ptr_reg];
    assign q_b     = b_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg] <= op_dec;
            a_mem[wr_ptr_reg]  <= a_wide[W-1:0];
            b_mem[wr_ptr_reg]  <= b_wide[W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> rtl/tia_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tia_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, on operand magnitudes.
// ----------------------------------------------------------------------------
module tia_div #(
    parameter int W = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire [W-1:0]  dividend,
    input  wire [W-1:0]  divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  div_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W:0]    partial, diff;

    assign partial = {rem_reg, quo_reg[W-1]};
    assign diff    = partial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> rtl/tia_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tia_back: execution of queued items
// Quotient or remainder by a nonzero divisor uses the divider; others do not.
// ----------------------------------------------------------------------------
module tia_back #(
    parameter int W = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_pop,
    input  wire tia_pkg::op_t   q_op,
    input  wire [W-1:0]         q_a,
    input  wire [W-1:0]         q_b,
    output logic                done,
    output tia_pkg::kind_t      result_kind,
    output logic signed [tia_pkg::VALUE_BITS-1:0] result_value
);
    localparam int  SW = $clog2(W);
    localparam int  EW = (W > tia_pkg::VALUE_BITS) ? W : tia_pkg::VALUE_BITS;
    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic                state_reg, state_next;
    logic                done_reg, done_next;
    tia_pkg::kind_t      kind_reg, kind_next;
    logic [W-1:0]        value_reg, value_next;
    logic                is_rem_reg, neg_q_reg, neg_r_reg;

    logic signed [W-1:0]   a_s, b_s;
    logic signed [W:0]     sum, dif, neg_b;
    logic signed [2*W-1:0] prod;
    logic [W-1:0]          a_mag, b_mag;
    logic                  div_start, div_done;
    logic [W-1:0]          div_quo, div_rem;
    logic [W-1:0]          shl_res, shr_res;
    logic [W:0]            right_n;
    logic signed [EW-1:0]  value_ext;

    assign a_s   = $signed(q_a);
    assign b_s   = $signed(q_b);
    assign sum   = (W+1)'(a_s) + (W+1)'(b_s);
    assign dif   = (W+1)'(a_s) - (W+1)'(b_s);
    assign prod  = (2*W)'(a_s) * (2*W)'(b_s);
    assign a_mag = q_a[W-1] ? (~q_a + 1'b1) : q_a;
    assign b_mag = q_b[W-1] ? (~q_b + 1'b1) : q_b;
    assign neg_b = -(W+1)'(b_s);

    // Shift: left for a non-negative count, arithmetic right otherwise.
    assign shl_res = ($unsigned(b_s) < W) ? (q_a << q_b[SW-1:0]) : '0;
    assign right_n = ($unsigned(neg_b) > (W - 1)) ? (W+1)'(W - 1) : $unsigned(neg_b);
    assign shr_res = $unsigned(a_s >>> right_n[SW-1:0]);

    assign q_pop     = q_valid && (state_reg == ST_RUN);
    assign div_start = q_pop && (q_op == tia_pkg::OP_QUO || q_op == tia_pkg::OP_REM)
                       && (q_b != '0);

    tia_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_mag),
        .divisor   (b_mag),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        kind_next  = tia_pkg::KIND_INT;
        value_next = '0;
        if (state_reg == ST_DIV)
        begin
            if (div_done)
            begin
                done_next  = 1'b1;
                state_next = ST_RUN;
                if (is_rem_reg)
                begin
                    value_next = neg_r_reg ? (~div_rem + 1'b1) : div_rem;
                end
                else if (!neg_q_reg && div_quo[W-1])
                begin
                    // Most negative value divided by minus one.
                    kind_next = tia_pkg::KIND_NIL;
                end
                else
                begin
                    value_next = neg_q_reg ? (~div_quo + 1'b1) : div_quo;
                end
            end
        end
        else if (q_pop)
        begin
            done_next = 1'b1;
            case (q_op)
                tia_pkg::OP_ADD:
                begin
                    if (sum[W] != sum[W-1]) kind_next = tia_pkg::KIND_NIL;
                    else                    value_next = sum[W-1:0];
                end
                tia_pkg::OP_SUB:
                begin
                    if (dif[W] != dif[W-1]) kind_next = tia_pkg::KIND_NIL;
                    else                    value_next = dif[W-1:0];
                end
                tia_pkg::OP_MUL:
                begin
                    if (prod != (2*W)'($signed(prod[W-1:0]))) kind_next = tia_pkg::KIND_NIL;
                    else                                       value_next = prod[W-1:0];
                end
                tia_pkg::OP_LT:
                    kind_next = (a_s < b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_GT:
                    kind_next = (a_s > b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_LE:
                    kind_next = (a_s <= b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_GE:
                    kind_next = (a_s >= b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_EQ:
                    kind_next = (a_s == b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_NE:
                    kind_next = (a_s != b_s) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
                tia_pkg::OP_QUO,
                tia_pkg::OP_REM:
                begin
                    if (q_b == '0)
                    begin
                        kind_next = tia_pkg::KIND_NIL;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
                tia_pkg::OP_AND:   value_next = q_a & q_b;
                tia_pkg::OP_XOR:   value_next = q_a ^ q_b;
                tia_pkg::OP_SHIFT: value_next = b_s[W-1] ? shr_res : shl_res;
                default:           value_next = q_a;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        if (div_start)
        begin
            is_rem_reg <= (q_op == tia_pkg::OP_REM);
            neg_q_reg  <= q_a[W-1] ^ q_b[W-1];
            neg_r_reg  <= q_a[W-1];
        end
    end

    assign value_ext    = EW'($signed(value_reg));
    assign done         = done_reg;
    assign result_kind  = kind_reg;
    assign result_value = value_ext[tia_pkg::VALUE_BITS-1:0];

endmodule
`default_nettype wire

>>> rtl/tagged_integer_alu.sv
`default_nettype none
// An accepted item is written to the queue, popped by the back end and then
// registered as the result with done; a quotient or remainder by a nonzero
// divisor passes through the bit-serial divider first, holding the back end.
// Throughput: one item per cycle while no division runs; busy rises once the
// two-entry queue fills. Results cannot be stalled by the receiver.
// Reset: rst_n clears the queue, the back-end state, the divider counter and
// the done strobe.
// ----------------------------------------------------------------------------
// tagged_integer_alu: integer operation unit for a small-integer machine
// A front end decodes and queues items; a back end executes them and drives
// one result per item, flagged by done for a single cycle.
// ----------------------------------------------------------------------------
module tagged_integer_alu #(
    parameter int INT_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire tia_pkg::cmd_t  cmd,
    input  wire logic signed [tia_pkg::VALUE_BITS-1:0] first_value,
    input  wire logic signed [tia_pkg::VALUE_BITS-1:0] second_value,
    output logic                done,
    output tia_pkg::kind_t      result_kind,
    output logic signed [tia_pkg::VALUE_BITS-1:0] result_value
);
    // Queue handoff between the two halves.
    logic               q_valid;
    logic               q_pop;
    tia_pkg::op_t       q_op;
    logic [INT_BITS-1:0] q_a;
    logic [INT_BITS-1:0] q_b;

    // The front end accepts an item whenever the queue has room.
    tia_front #(.W(INT_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .first_value  (first_value),
        .second_value (second_value),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .q_a          (q_a),
        .q_b          (q_b)
    );

    // The back end pops one item per cycle unless a division is running.
    tia_back #(.W(INT_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .q_a          (q_a),
        .q_b          (q_b),
        .done         (done),
        .result_kind  (result_kind),
        .result_value (result_value)
    );

endmodule
`default_nettype wire

>>> sim/tb_tagged_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_integer_alu: self-checking bench for the tagged integer ALU
// A directed table covers every opcode, the operand extremes, overflow, zero
// divisors and the shift limits. A random phase follows under three idling
// patterns. Every done strobe is checked in order against a local predictor.
// ----------------------------------------------------------------------------
module tb_tagged_integer_alu;

    localparam int N_BITS      = 16;
    localparam int RANDOM_N    = 1500;
    localparam int STALL_LIMIT = 2000;

    // An opcode outside the listed set; the block passes the first operand.
    localparam tia_pkg::cmd_t CMD_UNLISTED = 5'd31;

    // One row of the directed table. When has_kind is set, the kind and
    // value typed in the row must match the predictor as well.
    typedef struct packed {
        tia_pkg::cmd_t            op;
        logic signed [N_BITS-1:0] a;
        logic signed [N_BITS-1:0] b;
        logic                     has_kind;
        tia_pkg::kind_t           kind;
        logic signed [N_BITS-1:0] value;
    } row_t;

    typedef struct packed {
        tia_pkg::kind_t           kind;
        logic signed [N_BITS-1:0] value;
    } alu_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    tia_pkg::cmd_t            cmd;
    logic signed [N_BITS-1:0] first_value;
    logic signed [N_BITS-1:0] second_value;
    logic                     done;
    tia_pkg::kind_t           result_kind;
    logic signed [N_BITS-1:0] result_value;

    alu_result_t pending_results[$];
    int          error_count;
    int          items_sent;
    int          results_seen;
    int          idle_cycles;
    int          gap_percent;

    localparam logic signed [N_BITS-1:0] MAX_V = 16'sh7fff;
    localparam logic signed [N_BITS-1:0] MIN_V = -16'sh8000;

    row_t directed_rows[] = '{
        '{tia_pkg::CMD_ADD,   MAX_V,  16'sd1,  1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_ADD,   MIN_V,  -16'sd1, 1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_ADD,   MAX_V,  MIN_V,   1'b1, tia_pkg::KIND_INT,   -16'sd1},
        '{tia_pkg::CMD_SUB,   MIN_V,  16'sd1,  1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_SUB,   16'sd0, MIN_V,   1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_LT,    MIN_V,  MAX_V,   1'b1, tia_pkg::KIND_TRUE,  16'sd0},
        '{tia_pkg::CMD_GT,    MIN_V,  MAX_V,   1'b1, tia_pkg::KIND_FALSE, 16'sd0},
        '{tia_pkg::CMD_LE,    16'sd5, 16'sd5,  1'b1, tia_pkg::KIND_TRUE,  16'sd0},
        '{tia_pkg::CMD_GE,    -16'sd1, 16'sd0, 1'b1, tia_pkg::KIND_FALSE, 16'sd0},
        '{tia_pkg::CMD_EQ,    MIN_V,  MIN_V,   1'b1, tia_pkg::KIND_TRUE,  16'sd0},
        '{tia_pkg::CMD_NE,    MAX_V,  MAX_V,   1'b1, tia_pkg::KIND_FALSE, 16'sd0},
        '{tia_pkg::CMD_EQ2,   16'sd3, 16'sd4,  1'b1, tia_pkg::KIND_FALSE, 16'sd0},
        '{tia_pkg::CMD_MUL,   16'sd256, 16'sd128, 1'b1, tia_pkg::KIND_NIL, 16'sd0},
        '{tia_pkg::CMD_MUL,   -16'sd181, 16'sd181, 1'b0, tia_pkg::KIND_INT, 16'sd0},
        '{tia_pkg::CMD_QUO,   MIN_V,  -16'sd1, 1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_QUO,   16'sd7, 16'sd0,  1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_QUO,   -16'sd7, 16'sd2, 1'b1, tia_pkg::KIND_INT,   -16'sd3},
        '{tia_pkg::CMD_REM,   MIN_V,  -16'sd1, 1'b1, tia_pkg::KIND_INT,   16'sd0},
        '{tia_pkg::CMD_REM,   16'sd7, 16'sd0,  1'b1, tia_pkg::KIND_NIL,   16'sd0},
        '{tia_pkg::CMD_REM,   -16'sd7, 16'sd2, 1'b1, tia_pkg::KIND_INT,   -16'sd1},
        '{tia_pkg::CMD_AND,   -16'sd1, 16'sh5a5a, 1'b1, tia_pkg::KIND_INT, 16'sh5a5a},
        '{tia_pkg::CMD_XOR,   -16'sd1, 16'sh5a5a, 1'b0, tia_pkg::KIND_INT, 16'sd0},
        '{tia_pkg::CMD_SHIFT, 16'sd1, 16'sd15, 1'b1, tia_pkg::KIND_INT,   MIN_V},
        '{tia_pkg::CMD_SHIFT, 16'sd1, 16'sd16, 1'b1, tia_pkg::KIND_INT,   16'sd0},
        '{tia_pkg::CMD_SHIFT, MIN_V,  MIN_V,   1'b1, tia_pkg::KIND_INT,   -16'sd1},
        '{tia_pkg::CMD_SHIFT, MAX_V,  -16'sd16, 1'b1, tia_pkg::KIND_INT,  16'sd0},
        '{CMD_UNLISTED,       MIN_V,  MAX_V,   1'b1, tia_pkg::KIND_INT,   MIN_V}
    };

    tagged_integer_alu #(.INT_BITS(N_BITS)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .first_value  (first_value),
        .second_value (second_value),
        .done         (done),
        .result_kind  (result_kind),
        .result_value (result_value)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Computes the result of one operation at the block's width. Overflow is
    // judged on a wide intermediate so that the range test is exact.
    function automatic alu_result_t alu_predict(tia_pkg::cmd_t op,
                                                logic signed [N_BITS-1:0] a,
                                                logic signed [N_BITS-1:0] b);
        longint      wa;
        longint      wb;
        longint      wide;
        int          count;
        alu_result_t r;
        wa    = a;
        wb    = b;
        wide  = wa;
        r.kind = tia_pkg::KIND_INT;
        case (op)
            tia_pkg::CMD_ADD: wide = wa + wb;
            tia_pkg::CMD_SUB: wide = wa - wb;
            tia_pkg::CMD_MUL: wide = wa * wb;
            tia_pkg::CMD_QUO:
                if (wb == 0) r.kind = tia_pkg::KIND_NIL; else wide = wa / wb;
            tia_pkg::CMD_REM:
                if (wb == 0) r.kind = tia_pkg::KIND_NIL; else wide = wa % wb;
            tia_pkg::CMD_AND: wide = a & b;
            tia_pkg::CMD_XOR: wide = a ^ b;
            tia_pkg::CMD_LT:
                r.kind = (a <  b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_GT:
                r.kind = (a >  b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_LE:
                r.kind = (a <= b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_GE:
                r.kind = (a >= b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_EQ, tia_pkg::CMD_EQ2:
                r.kind = (a == b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_NE:
                r.kind = (a != b) ? tia_pkg::KIND_TRUE : tia_pkg::KIND_FALSE;
            tia_pkg::CMD_SHIFT:
            begin
                count = b;
                if (count >= N_BITS)
                    wide = 0;
                else if (count >= 0)
                    wide = $signed(a << count);
                else
                    wide = a >>> ((-count > N_BITS - 1) ? N_BITS - 1 : -count);
            end
            default: wide = wa;
        endcase
        if (r.kind == tia_pkg::KIND_INT && (wide > MAX_V || wide < MIN_V))
            r.kind = tia_pkg::KIND_NIL;
        r.value = (r.kind == tia_pkg::KIND_INT) ? N_BITS'(wide) : '0;
        return r;
    endfunction

    // Drives one item and holds it until the block takes it. Start stays
    // high across back-to-back items so it is never dropped and raised in one
    // step. Random gaps are inserted ahead of the item.
    task automatic issue_item(tia_pkg::cmd_t op, logic signed [N_BITS-1:0] a,
                              logic signed [N_BITS-1:0] b);
        while ($urandom_range(99, 0) < gap_percent)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= op;
        first_value  <= a;
        second_value <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(alu_predict(op, a, b));
        items_sent++;
    endtask

    // Biased operands so that extremes, zero and small counts come up often.
    function automatic logic signed [N_BITS-1:0] pick_operand();
        case ($urandom_range(7, 0))
            0: return MAX_V;
            1: return MIN_V;
            2: return 16'($signed($urandom_range(2, 0)) - 1);
            3: return 16'($signed($urandom_range(40, 0)) - 20);
            4: return 16'($signed($urandom_range(400, 0)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tia_pkg::cmd_t pick_cmd();
        if ($urandom_range(9, 0) == 0)
            return tia_pkg::cmd_t'($urandom_range(31, 14));
        else if ($urandom_range(4, 0) == 0)
            return tia_pkg::CMD_SHIFT;
        return tia_pkg::cmd_t'($urandom_range(13, 0));
    endfunction

    // Checker: the receiver cannot stall, so each strobe is matched straight
    // away against the oldest prediction. Busy is sampled at the edge, so it
    // needs no special handling here.
    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d value %0d",
                       result_kind, result_value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                    error_count++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", want.value, result_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("tb_tagged_integer_alu: errors");
            $finish;
        end
    end

    initial
    begin
        alu_result_t typed;
        int          phase;
        int          n;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        gap_percent  = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = tia_pkg::CMD_ADD;
        first_value  = '0;
        second_value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows are also held against the predictor so
        // a slip in either one shows up.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_kind)
            begin
                typed = alu_predict(directed_rows[i].op, directed_rows[i].a,
                                    directed_rows[i].b);
                if (typed.kind !== directed_rows[i].kind
                    || typed.value !== directed_rows[i].value)
                begin
                    $error("table row %0d: typed kind %0d value %0d, predicted %0d %0d", i,
                           directed_rows[i].kind, directed_rows[i].value,
                           typed.kind, typed.value);
                    error_count++;
                end
            end
            issue_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b);
        end

        // Pause until the block drains, so the random phase starts on an empty queue.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // Random phase: the sender idles sometimes, then often, then never.
        for (phase = 0; phase < 3; phase++)
        begin
            gap_percent = (phase == 0) ? 32 : (phase == 1) ? 82 : 0;
            for (n = 0; n < RANDOM_N / 3; n++)
                issue_item(pick_cmd(), pick_operand(), pick_operand());
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * N_BITS + 8) @(posedge clk);

        $display("Sent %0d items over all opcodes, extremes and three idling patterns;",
                 items_sent);
        $display("checked %0d results against the predictor.", results_seen);
        if (error_count == 0)
            $display("tb_tagged_integer_alu: clean");
        else
            $display("tb_tagged_integer_alu: errors");
        $finish;
    end

endmodule
